// ===== sv/source_tokenizer_top_macros.svh =====
// Assertion macros for the source tokenizer.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef SOURCE_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTH
`define STOK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("source tokenizer: assertion failed");
`define STOK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("source tokenizer: assertion failed");
`else
`define STOK_ASSERT_IMP(lbl, ante, cons)
`define STOK_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/stok_pkg.sv =====
// Shared types, constants and helper functions of the source tokenizer.
// No dependencies; used by the front end, queue, back end and top level.
package stok_pkg;

  localparam int POS_BITS = 16;
  localparam int OUT_BITS = 16;
  localparam int OUT_MAX = 65535;
  localparam int CMP_BITS = (POS_BITS + 1 > OUT_BITS + 1) ? POS_BITS + 1 : OUT_BITS + 1;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  localparam logic [4:0] KIND_EOS = 5'd0;
  localparam logic [4:0] KIND_IDENT = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_STRING = 5'd3;
  localparam logic [4:0] KIND_LPAREN = 5'd4;
  localparam logic [4:0] KIND_RPAREN = 5'd5;
  localparam logic [4:0] KIND_LBRACE = 5'd6;
  localparam logic [4:0] KIND_RBRACE = 5'd7;
  localparam logic [4:0] KIND_LT = 5'd8;
  localparam logic [4:0] KIND_GT = 5'd9;
  localparam logic [4:0] KIND_DOT = 5'd10;
  localparam logic [4:0] KIND_COMMA = 5'd11;
  localparam logic [4:0] KIND_COLON = 5'd12;
  localparam logic [4:0] KIND_SEMI = 5'd13;
  localparam logic [4:0] KIND_APOS = 5'd14;
  localparam logic [4:0] KIND_EQ = 5'd15;
  localparam logic [4:0] KIND_PLUS = 5'd16;
  localparam logic [4:0] KIND_MINUS = 5'd17;
  localparam logic [4:0] KIND_STAR = 5'd18;
  localparam logic [4:0] KIND_AMP = 5'd19;
  localparam logic [4:0] KIND_CARET = 5'd20;
  localparam logic [4:0] KIND_SLASH = 5'd21;
  localparam logic [4:0] KIND_BSLASH = 5'd22;
  localparam logic [4:0] KIND_BANG = 5'd23;
  localparam logic [4:0] KIND_QMARK = 5'd24;
  localparam logic [4:0] KIND_HASH = 5'd25;
  localparam logic [4:0] KIND_PIPE = 5'd26;
  localparam logic [4:0] KIND_ERROR = 5'd27;

  typedef enum logic [4:0] {
    M_IDLE   = 5'b00001,
    M_IDENT  = 5'b00010,
    M_NUMBER = 5'b00100,
    M_STRING = 5'b01000,
    M_ESC    = 5'b10000
  } scan_mode_t;

  typedef struct packed {
    logic [4:0]          kind;
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] len;
  } tok_rec_t;

  typedef struct packed {
    logic     two;
    tok_rec_t r0;
    tok_rec_t r1;
  } q_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h7B: k = KIND_LBRACE;
      8'h7D: k = KIND_RBRACE;
      8'h5B: k = KIND_LBRACE;
      8'h5D: k = KIND_RBRACE;
      8'h3C: k = KIND_LT;
      8'h3E: k = KIND_GT;
      8'h2E: k = KIND_DOT;
      8'h2C: k = KIND_COMMA;
      8'h3A: k = KIND_COLON;
      8'h3B: k = KIND_SEMI;
      8'h27: k = KIND_APOS;
      8'h3D: k = KIND_EQ;
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_STAR;
      8'h26: k = KIND_AMP;
      8'h5E: k = KIND_CARET;
      8'h2F: k = KIND_SLASH;
      8'h5C: k = KIND_BSLASH;
      8'h21: k = KIND_BANG;
      8'h3F: k = KIND_QMARK;
      8'h23: k = KIND_HASH;
      8'h7C: k = KIND_PIPE;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [OUT_BITS-1:0] clamp_out(input logic [CMP_BITS-1:0] v);
    logic [OUT_BITS-1:0] r;
    if (v > CMP_BITS'(OUT_MAX)) begin
      r = '1;
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

  function automatic tok_rec_t mk_rec(input logic [4:0] kind, input logic [POS_BITS-1:0] start,
                                      input logic [CMP_BITS-1:0] len);
    tok_rec_t r;
    r.kind = kind;
    r.start = clamp_out(CMP_BITS'(start));
    r.len = clamp_out(len);
    return r;
  endfunction

endpackage

// ===== sv/stok_in_if.sv =====
// Input channel of the source tokenizer: one source byte or end mark per word.
// Depends on nothing.
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source(output valid, output source_byte, output end_of_source, input ready);
  modport sink(input valid, input source_byte, input end_of_source, output ready);
endinterface

// ===== sv/stok_out_if.sv =====
// Result channel of the source tokenizer: one token record per word.
// Depends on nothing.
interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source(output valid, output token_kind, output token_start, output token_length,
                 output last_of_run, input ready);
  modport sink(input valid, input token_kind, input token_start, input token_length,
               input last_of_run, output ready);
endinterface

// ===== sv/stok_front.sv =====
// Front end: accepts source words, tracks scan mode and position, builds token records.
// Depends on stok_pkg and stok_in_if.
module stok_front (
  input  logic               clk,
  input  logic               rst_n,
  stok_in_if.sink            in_ch,
  input  stok_pkg::q_stat_t  stat,
  output logic               push,
  output stok_pkg::q_ent_t   push_ent
);

  stok_pkg::scan_mode_t            mode_r, mode_nxt;
  logic [stok_pkg::POS_BITS-1:0]   start_r, start_nxt;
  logic [stok_pkg::POS_BITS-1:0]   pos_r, pos_nxt;
  logic                            acc;
  logic [7:0]                      c;
  logic [stok_pkg::POS_BITS-1:0]   open_len;
  logic [stok_pkg::CMP_BITS-1:0]   open_len_x;
  stok_pkg::scan_mode_t            f_mode;
  logic [stok_pkg::POS_BITS-1:0]   f_start;
  logic                            f_emit;
  stok_pkg::tok_rec_t              f_rec;
  stok_pkg::tok_rec_t              r0, r1;
  logic [1:0]                      cnt;

  assign in_ch.ready = !stat.full;
  assign acc = in_ch.valid && in_ch.ready;
  assign c = in_ch.source_byte;

  always_comb begin
    open_len = (pos_r >= start_r) ? (pos_r - start_r) : '0;
    open_len_x = stok_pkg::CMP_BITS'(open_len);

    f_mode = stok_pkg::M_IDLE;
    f_start = start_r;
    f_emit = 1'b0;
    if (stok_pkg::is_space(c)) begin
      f_mode = stok_pkg::M_IDLE;
    end else if (stok_pkg::is_alpha(c) || c == stok_pkg::CH_UNDERSCORE) begin
      f_mode = stok_pkg::M_IDENT;
      f_start = pos_r;
    end else if (stok_pkg::is_digit(c)) begin
      f_mode = stok_pkg::M_NUMBER;
      f_start = pos_r;
    end else if (c == stok_pkg::CH_QUOTE) begin
      f_mode = stok_pkg::M_STRING;
      f_start = pos_r;
    end else begin
      f_emit = 1'b1;
    end
    f_rec = stok_pkg::mk_rec(stok_pkg::punct_kind(c), pos_r, stok_pkg::CMP_BITS'(1));

    mode_nxt = mode_r;
    start_nxt = start_r;
    pos_nxt = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
    cnt = 2'd0;
    r0 = f_rec;
    r1 = f_rec;

    if (in_ch.end_of_source) begin
      mode_nxt = stok_pkg::M_IDLE;
      start_nxt = '0;
      pos_nxt = '0;
      case (mode_r)
        stok_pkg::M_IDENT: begin
          r0 = stok_pkg::mk_rec(stok_pkg::KIND_IDENT, start_r, open_len_x);
          cnt = 2'd2;
        end
        stok_pkg::M_NUMBER: begin
          r0 = stok_pkg::mk_rec(stok_pkg::KIND_NUMBER, start_r, open_len_x);
          cnt = 2'd2;
        end
        stok_pkg::M_STRING, stok_pkg::M_ESC: begin
          r0 = stok_pkg::mk_rec(stok_pkg::KIND_ERROR, start_r, open_len_x);
          cnt = 2'd2;
        end
        default: begin
          cnt = 2'd1;
        end
      endcase
      if (cnt == 2'd2) begin
        r1 = stok_pkg::mk_rec(stok_pkg::KIND_EOS, pos_r, '0);
      end else begin
        r0 = stok_pkg::mk_rec(stok_pkg::KIND_EOS, pos_r, '0);
      end
    end else begin
      case (mode_r)
        stok_pkg::M_IDENT, stok_pkg::M_NUMBER: begin
          if ((mode_r == stok_pkg::M_NUMBER && !stok_pkg::is_digit(c)) ||
              (mode_r == stok_pkg::M_IDENT && !(stok_pkg::is_alpha(c) ||
               stok_pkg::is_digit(c) || c == stok_pkg::CH_UNDERSCORE))) begin
            r0 = stok_pkg::mk_rec((mode_r == stok_pkg::M_IDENT) ? stok_pkg::KIND_IDENT :
                                  stok_pkg::KIND_NUMBER, start_r, open_len_x);
            cnt = f_emit ? 2'd2 : 2'd1;
            mode_nxt = f_mode;
            start_nxt = f_start;
          end
        end
        stok_pkg::M_STRING: begin
          if (c == stok_pkg::CH_BACKSLASH) begin
            mode_nxt = stok_pkg::M_ESC;
          end else if (c == stok_pkg::CH_QUOTE) begin
            r0 = stok_pkg::mk_rec(stok_pkg::KIND_STRING, start_r,
                                  open_len_x + stok_pkg::CMP_BITS'(1));
            cnt = 2'd1;
            mode_nxt = stok_pkg::M_IDLE;
          end
        end
        stok_pkg::M_ESC: begin
          mode_nxt = stok_pkg::M_STRING;
        end
        default: begin
          mode_nxt = f_mode;
          start_nxt = f_start;
          cnt = f_emit ? 2'd1 : 2'd0;
        end
      endcase
    end
  end

  assign push = acc && (cnt != 2'd0);
  assign push_ent.two = (cnt == 2'd2);
  assign push_ent.r0 = r0;
  assign push_ent.r1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stok_pkg::M_IDLE;
      start_r <= '0;
      pos_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      start_r <= start_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== sv/stok_fifo.sv =====
// Short queue of token entries between the front and back ends.
// Depends on stok_pkg and the assertion macros.
`include "source_tokenizer_top_macros.svh"
module stok_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  stok_pkg::q_ent_t   push_ent,
  input  logic               pop,
  output stok_pkg::q_ent_t   head,
  output stok_pkg::q_stat_t  stat
);

  stok_pkg::q_ent_t                mem_r [stok_pkg::QDEPTH];
  logic [stok_pkg::QPTR_BITS-1:0]  wptr_r, rptr_r;
  logic [stok_pkg::QPTR_BITS:0]    cnt_r, cnt_nxt;

  assign head = mem_r[rptr_r];
  assign stat.full = (cnt_r == (stok_pkg::QPTR_BITS + 1)'(stok_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_ent;
    end
  end

  `STOK_ASSERT_IMP(a_no_overflow, push, !stat.full)
  `STOK_ASSERT_IMP(a_no_underflow, pop, !stat.empty)
  `STOK_ASSERT_NXT(a_count_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1)
  `STOK_ASSERT_IMP(a_ptr_match, stat.empty, wptr_r == rptr_r)

endmodule

// ===== sv/stok_back.sv =====
// Back end: splits queue entries into single token words in an output register.
// Depends on stok_pkg and stok_out_if.
module stok_back (
  input  logic               clk,
  input  logic               rst_n,
  input  stok_pkg::q_ent_t   head,
  input  stok_pkg::q_stat_t  stat,
  output logic               pop,
  stok_out_if.source         out_ch
);

  logic                ov_r;
  logic                sel_r;
  stok_pkg::tok_rec_t  rec_r;
  logic                last_r;
  logic                load;
  logic                take;
  logic                fin;

  assign load = !ov_r || out_ch.ready;
  assign take = load && !stat.empty;
  assign fin = sel_r || !head.two;
  assign pop = take && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sel_r <= 1'b0;
    end else if (load) begin
      ov_r <= !stat.empty;
      if (take) begin
        sel_r <= !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_r <= sel_r ? head.r1 : head.r0;
      last_r <= fin;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.token_kind = rec_r.kind;
  assign out_ch.token_start = rec_r.start;
  assign out_ch.token_length = rec_r.len;
  assign out_ch.last_of_run = last_r;

endmodule

// ===== sv/source_tokenizer_top.sv =====
// Top level of the source tokenizer: front end, entry queue, back end.
// Depends on stok_pkg, stok_in_if, stok_out_if, stok_front, stok_fifo, stok_back.
//
//   port     dir  word
//   in_ch    in   source_byte[8], end_of_source[1]
//   out_ch   out  token_kind[5], token_start[16], token_length[16], last_of_run[1]
//
// One source word is taken per cycle while the four-entry queue has room.
// A word that closes a token and starts a punctuation token, or an end mark after an
// open token, puts two token words through the output register; the queue absorbs such bursts.
// An accepted word's token words pass through the queue memory and then the output register.
// Reset (synchronous, rst_n low) clears scan mode, position and queue pointers.
// in_ch.ready drops only while the queue is full; out_ch stalls hold the output register.
module source_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  stok_in_if.sink     in_ch,
  stok_out_if.source  out_ch
);

  logic               push;
  logic               pop;
  stok_pkg::q_ent_t   push_ent;
  stok_pkg::q_ent_t   head;
  stok_pkg::q_stat_t  stat;

  stok_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .stat     (stat),
    .push     (push),
    .push_ent (push_ent)
  );

  stok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  stok_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
